[hw/rtl/qop_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the queued output pulser.
// No dependencies; imported by qop_ram and queued_output_pulser.
package qop_pkg;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ON       = 2'd1,
        PH_RECHARGE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_STEP_RD,
        ST_STEP_EX,
        ST_OUT
    } state_t;

    localparam logic [1:0] CFG_ON_MS        = 2'd0;
    localparam logic [1:0] CFG_RECHARGE_MS  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_LEVEL = 2'd2;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam int unsigned PIN_W = 8;
    localparam int unsigned MS_W  = 16;

endpackage

[hw/rtl/queued_output_pulser.sv]
`timescale 1ns / 1ps
// Queued output pulser: fires pin pulses one at a time from a circular pin queue.
// Input channel s_*: op 0 requests a pulse of s_pin, op 1 is a one millisecond tick.
// Result channel m_*: one transaction per input transaction with the queue slot,
// a full flag, at most one pin drive event and the sequencer phase after the step.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 on_ms,
// 1 recharge_ms, 2 active_level) and must be used only while the block is idle.
// A tick passes through the states STEP_RD, STEP_EX and OUT; m_valid rises as it
// leaves OUT. A request scans the queue one slot per cycle through the single
// read port of the queue RAM; a pin that is appended then passes through APPEND,
// STEP_RD and STEP_EX before OUT. One transaction is in work at a time.
// The result sits in an output register, so the next input transaction is
// accepted while a finished result waits; if the receiver stalls and a second
// result is ready, the block holds it until the output register drains.
// Reset (aresetn low, synchronous) empties the queue, sets the phase to idle,
// clears the countdown and loads the register reset values. The queue RAM needs
// no clearing pass: only entries inside the occupancy count are ever used.
module queued_output_pulser
    import qop_pkg::*;
#(
    parameter int unsigned QUEUE_SLOTS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [MS_W-1:0]  cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_op,
    input  logic [PIN_W-1:0] s_pin,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_add_slot,
    output logic             m_add_full,
    output logic             m_drive_valid,
    output logic [PIN_W-1:0] m_drive_pin,
    output logic             m_drive_level,
    output logic [1:0]       m_phase
);

    localparam int unsigned AW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(QUEUE_SLOTS + 1);
    localparam int unsigned SW = CW + 1;

    // Circular address: base + offset, folded back into the queue.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_SLOTS)) begin
            sum = sum - SW'(QUEUE_SLOTS);
        end
        return sum[AW-1:0];
    endfunction

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [MS_W-1:0]  rem_reg, rem_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             op_reg, op_next;
    logic [PIN_W-1:0] pin_reg, pin_next;

    logic [MS_W-1:0]  on_ms_reg, recharge_ms_reg;
    logic             active_level_reg;

    logic [CW-1:0]    slot_reg, slot_next;
    logic             full_reg, full_next;
    logic             dv_reg, dv_next;
    logic [PIN_W-1:0] dpin_reg, dpin_next;
    logic             dlvl_reg, dlvl_next;

    logic             m_valid_reg;
    logic [2:0]       m_slot_reg;
    logic             m_full_reg, m_dv_reg, m_dlvl_reg;
    logic [PIN_W-1:0] m_dpin_reg;
    logic [1:0]       m_phase_reg;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [PIN_W-1:0] rd_data;

    logic             in_fire;
    logic             out_free;
    logic             last_idx;
    logic             hit;
    logic [CW+2:0]    slot_ext;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = (SW'(idx_reg) + SW'(1)) >= SW'(count_reg);
    assign hit      = (rd_data == pin_reg);
    assign slot_ext = {3'b000, slot_reg};

    qop_ram #(
        .DEPTH (QUEUE_SLOTS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pin_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_op == OP_TICK) begin
                        state_next = ST_STEP_RD;
                    end else if (count_reg == '0) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_OUT;
                end else if (last_idx) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (count_reg == CW'(QUEUE_SLOTS)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_STEP_RD;
                end
            end
            ST_STEP_RD: state_next = ST_STEP_EX;
            ST_STEP_EX: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        pin_next   = pin_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        dv_next    = dv_reg;
        dpin_next  = dpin_reg;
        dlvl_next  = dlvl_reg;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = wrap_add(head_reg, count_reg);
        s_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    op_next   = s_op;
                    pin_next  = s_pin;
                    slot_next = '0;
                    full_next = 1'b0;
                    dv_next   = 1'b0;
                    dpin_next = '0;
                    dlvl_next = 1'b0;
                    idx_next  = '0;
                    if (s_op == OP_TICK) begin
                        if (rem_reg != '0) begin
                            rem_next = rem_reg - MS_W'(1);
                        end
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = head_reg;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    slot_next = idx_reg;
                end else if (!last_idx) begin
                    idx_next = idx_reg + CW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = wrap_add(head_reg, idx_reg + CW'(1));
                end
            end
            ST_APPEND: begin
                if (count_reg == CW'(QUEUE_SLOTS)) begin
                    full_next = 1'b1;
                    slot_next = '0;
                end else begin
                    wr_en      = 1'b1;
                    slot_next  = count_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            ST_STEP_RD: begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
            end
            ST_STEP_EX: begin
                case (phase_reg)
                    PH_ON: begin
                        if (rem_reg == '0) begin
                            dv_next    = 1'b1;
                            dpin_next  = rd_data;
                            dlvl_next  = !active_level_reg;
                            head_next  = wrap_add(head_reg, CW'(1));
                            count_next = count_reg - CW'(1);
                            rem_next   = recharge_ms_reg;
                            phase_next = PH_RECHARGE;
                        end
                    end
                    PH_RECHARGE: begin
                        if (rem_reg == '0) begin
                            if (count_reg != '0) begin
                                dv_next    = 1'b1;
                                dpin_next  = rd_data;
                                dlvl_next  = active_level_reg;
                                rem_next   = on_ms_reg;
                                phase_next = PH_ON;
                            end else begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        if (count_reg != '0) begin
                            dv_next    = 1'b1;
                            dpin_next  = rd_data;
                            dlvl_next  = active_level_reg;
                            rem_next   = on_ms_reg;
                            phase_next = PH_ON;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_IDLE;
            rem_reg          <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            on_ms_reg        <= '0;
            recharge_ms_reg  <= '0;
            active_level_reg <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ON_MS:        on_ms_reg        <= cfg_data;
                    CFG_RECHARGE_MS:  recharge_ms_reg  <= cfg_data;
                    CFG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        pin_reg  <= pin_next;
        slot_reg <= slot_next;
        full_reg <= full_next;
        dv_reg   <= dv_next;
        dpin_reg <= dpin_next;
        dlvl_reg <= dlvl_next;
        if (state_reg == ST_OUT && out_free) begin
            m_slot_reg  <= slot_ext[2:0];
            m_full_reg  <= full_reg;
            m_dv_reg    <= dv_reg;
            m_dpin_reg  <= dpin_reg;
            m_dlvl_reg  <= dlvl_reg;
            m_phase_reg <= phase_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_add_slot    = m_slot_reg;
    assign m_add_full    = m_full_reg;
    assign m_drive_valid = m_dv_reg;
    assign m_drive_pin   = m_dpin_reg;
    assign m_drive_level = m_dlvl_reg;
    assign m_phase       = m_phase_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_SLOTS))
        else $error("queue occupancy above capacity");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(head_reg) < SW'(QUEUE_SLOTS))
        else $error("head pointer outside the queue");

    a_on_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ON |-> count_reg != '0)
        else $error("pulse phase with an empty queue");

    a_ticks_keep_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_EX && op_reg == OP_TICK && phase_reg != PH_ON)
            |=> $stable(count_reg))
        else $error("queue occupancy changed outside a pulse end");

    a_full_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && full_reg) |-> !dv_reg)
        else $error("full request produced a pin drive");
`endif

endmodule

[hw/rtl/qop_ram.sv]
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM holding queued pins.
// Read data is registered. Depends on qop_pkg.
module qop_ram
    import qop_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIN_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIN_W-1:0] rd_data
);

    logic [PIN_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/sv/queued_output_pulser_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for queued_output_pulser: sends pulse requests and ticks,
// predicts each result with a behavioral model of the pin queue and sequencer.
// Depends on qop_pkg and the queued_output_pulser RTL.
module queued_output_pulser_tb;
    import qop_pkg::*;

    localparam int unsigned QSLOTS = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int POOL_SIZE = 12;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [PIN_W-1:0] SLOT_FREE = 8'd255;

    typedef struct packed {
        logic [2:0]       add_slot;
        logic             add_full;
        logic             drive_valid;
        logic [PIN_W-1:0] drive_pin;
        logic             drive_level;
        logic [1:0]       phase;
    } pulse_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [MS_W-1:0]  cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_op = OP_REQUEST;
    logic [PIN_W-1:0] s_pin = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [2:0]       m_add_slot;
    logic             m_add_full;
    logic             m_drive_valid;
    logic [PIN_W-1:0] m_drive_pin;
    logic             m_drive_level;
    logic [1:0]       m_phase;

    queued_output_pulser #(
        .QUEUE_SLOTS(QSLOTS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_pin        (s_pin),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_add_slot   (m_add_slot),
        .m_add_full   (m_add_full),
        .m_drive_valid(m_drive_valid),
        .m_drive_pin  (m_drive_pin),
        .m_drive_level(m_drive_level),
        .m_phase      (m_phase)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Behavioral copy of the pin queue, sequencer and registers
    logic [PIN_W-1:0] pin_queue [QSLOTS];
    int unsigned      queue_fill;
    phase_t           seq_ph;
    logic [MS_W-1:0]  ms_left;
    logic [MS_W-1:0]  on_len;
    logic [MS_W-1:0]  rest_len;
    logic             act_lvl;

    pulse_result_t    pending_pulse_results [$];
    logic [PIN_W-1:0] pin_pool [POOL_SIZE];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int pulses_started = 0;
    int dup_requests = 0;
    int full_rejects = 0;

    function automatic pulse_result_t start_head(input pulse_result_t r);
        pulse_result_t res;
        res = r;
        res.drive_valid = 1'b1;
        res.drive_pin = pin_queue[0];
        res.drive_level = act_lvl;
        ms_left = on_len;
        seq_ph = PH_ON;
        pulses_started++;
        return res;
    endfunction

    function automatic pulse_result_t seq_advance(input pulse_result_t r);
        pulse_result_t res;
        res = r;
        case (seq_ph)
            PH_ON: begin
                if (ms_left == '0) begin
                    res.drive_valid = 1'b1;
                    res.drive_pin = pin_queue[0];
                    res.drive_level = ~act_lvl;
                    if (queue_fill > 0) begin
                        for (int i = 0; i + 1 < QSLOTS; i++)
                            pin_queue[i] = pin_queue[i + 1];
                        pin_queue[QSLOTS - 1] = SLOT_FREE;
                        queue_fill--;
                    end
                    ms_left = rest_len;
                    seq_ph = PH_RECHARGE;
                end
            end
            PH_RECHARGE: begin
                if (ms_left == '0) begin
                    if (queue_fill > 0)
                        res = start_head(res);
                    else
                        seq_ph = PH_IDLE;
                end
            end
            default: begin
                seq_ph = PH_IDLE;
                if (queue_fill > 0)
                    res = start_head(res);
            end
        endcase
        return res;
    endfunction

    function automatic pulse_result_t predict_pulse(input logic op,
                                                    input logic [PIN_W-1:0] pin);
        pulse_result_t r;
        int            slot;
        bit            found;
        r = '0;
        slot = 0;
        found = 1'b0;
        if (op == OP_TICK) begin
            if (ms_left != '0)
                ms_left = ms_left - MS_W'(1);
            r = seq_advance(r);
        end else begin
            for (int i = 0; i < queue_fill; i++) begin
                if (!found && pin_queue[i] == pin) begin
                    found = 1'b1;
                    slot = i;
                end
            end
            if (found) begin
                dup_requests++;
            end else if (queue_fill < QSLOTS) begin
                slot = queue_fill;
                pin_queue[queue_fill] = pin;
                queue_fill++;
                r = seq_advance(r);
            end else begin
                full_rejects++;
                r.add_full = 1'b1;
            end
        end
        r.add_slot = slot[2:0];
        r.phase = seq_ph;
        return r;
    endfunction

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        pulse_result_t got;
        pulse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.add_slot = m_add_slot;
            got.add_full = m_add_full;
            got.drive_valid = m_drive_valid;
            got.drive_pin = m_drive_pin;
            got.drive_level = m_drive_level;
            got.phase = m_phase;
            if (pending_pulse_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result with nothing expected: ",
                              "slot=%0d full=%0d drv=%0d pin=%0d lvl=%0d ph=%0d"},
                             $realtime, got.add_slot, got.add_full, got.drive_valid,
                             got.drive_pin, got.drive_level, got.phase);
            end else begin
                want = pending_pulse_results.pop_front();
                results_checked++;
                if (got.add_slot !== want.add_slot || got.add_full !== want.add_full ||
                    got.drive_valid !== want.drive_valid || got.drive_pin !== want.drive_pin ||
                    got.drive_level !== want.drive_level || got.phase !== want.phase) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"%0t: mismatch exp ",
                                  "slot=%0d full=%0d drv=%0d pin=%0d lvl=%0d ph=%0d"},
                                 $realtime, want.add_slot, want.add_full, want.drive_valid,
                                 want.drive_pin, want.drive_level, want.phase);
                        $display({"%0t:          got ",
                                  "slot=%0d full=%0d drv=%0d pin=%0d lvl=%0d ph=%0d"},
                                 $realtime, got.add_slot, got.add_full, got.drive_valid,
                                 got.drive_pin, got.drive_level, got.phase);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                     pending_pulse_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic op, input logic [PIN_W-1:0] pin);
        pulse_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = op;
        s_pin = pin;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = predict_pulse(op, pin);
        pending_pulse_results.push_back(r);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid = 1'b0;
        while (pending_pulse_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [MS_W-1:0] val);
        s_valid = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ON_MS:        on_len = val;
            CFG_RECHARGE_MS:  rest_len = val;
            CFG_ACTIVE_LEVEL: act_lvl = val[0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [MS_W-1:0] on, input logic [MS_W-1:0] rest,
                              input logic lvl);
        wait_results_drained();
        write_reg(CFG_ON_MS, on);
        write_reg(CFG_RECHARGE_MS, rest);
        write_reg(CFG_ACTIVE_LEVEL, {{(MS_W-1){1'b0}}, lvl});
    endtask

    // Mostly ticks and requests from a small pool, so pins repeat and the
    // queue both fills and drains; occasional bursts of fresh pins force full
    task automatic run_traffic(input int n);
        int k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(99) < 4) begin
                repeat (QSLOTS + 1) begin
                    send_item(OP_REQUEST, PIN_W'($urandom_range(255)));
                    k++;
                end
            end else begin
                if ($urandom_range(99) < 55)
                    send_item(OP_TICK, PIN_W'($urandom_range(255)));
                else if ($urandom_range(99) < 70)
                    send_item(OP_REQUEST, pin_pool[$urandom_range(POOL_SIZE - 1)]);
                else
                    send_item(OP_REQUEST, PIN_W'($urandom_range(255)));
                k++;
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        // Reset timing: zero on and recharge, active high
        send_item(OP_TICK, 8'hA5);
        send_item(OP_REQUEST, 8'd0);
        send_item(OP_REQUEST, 8'd0);
        send_item(OP_REQUEST, 8'd255);
        set_timing(16'd3, 16'd2, 1'b1);
        for (int b = 0; b < PIN_W; b++)
            send_item(OP_REQUEST, 8'd1 << b);
        send_item(OP_REQUEST, 8'd170);
        send_item(OP_REQUEST, 8'd128);
        repeat (8) send_item(OP_TICK, 8'h5A);
    endtask

    task automatic test_random_phase(input int n, input logic [MS_W-1:0] on,
                                     input logic [MS_W-1:0] rest, input logic lvl,
                                     input int snd_idle, input int rcv_stall);
        set_timing(on, rest, lvl);
        send_idle_pct = snd_idle;
        stall_pct = rcv_stall;
        for (int i = 0; i < POOL_SIZE; i++)
            pin_pool[i] = PIN_W'($urandom_range(255));
        run_traffic(n);
    endtask

    task automatic test_backpressure();
        set_timing(16'd0, 16'd2, 1'b1);
        send_idle_pct = 31;
        stall_pct = 31;
        // Stop the receiver for a long stretch and keep offering transactions
        hold_left = HOLD_OFF_CYCLES;
        run_traffic(40);
        run_traffic(260);
    endtask

    task automatic test_extremes();
        set_timing(16'd0, 16'd0, 1'b1);
        send_idle_pct = 0;
        stall_pct = 0;
        while (queue_fill > 0 || seq_ph != PH_IDLE)
            send_item(OP_TICK, 8'h00);
        set_timing(16'd0, 16'hFFFF, 1'b1);
        send_item(OP_REQUEST, 8'd77);
        send_item(OP_TICK, 8'hFF);
        for (int i = 0; i <= QSLOTS; i++)
            send_item(OP_REQUEST, PIN_W'(100 + i));
        // Tick into the longest recharge; the countdown stays far from zero
        repeat (40)
            send_item(OP_TICK, PIN_W'($urandom_range(255)));
        set_timing(16'hFFFF, 16'd0, 1'b0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        repeat (2) send_item(OP_TICK, 8'h00);
        send_item(OP_REQUEST, 8'd102);
        repeat (4) send_item(OP_REQUEST, PIN_W'($urandom_range(255)));
        repeat (5) send_item(OP_TICK, 8'hFF);
    endtask

    initial begin
        for (int i = 0; i < QSLOTS; i++)
            pin_queue[i] = SLOT_FREE;
        queue_fill = 0;
        seq_ph = PH_IDLE;
        ms_left = '0;
        on_len = '0;
        rest_len = '0;
        act_lvl = 1'b1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_phase(250, 16'd2, 16'd1, 1'b1, 0, 0);
        test_random_phase(250, 16'd0, 16'd0, 1'b0, 48, 0);
        test_random_phase(250, 16'd5, 16'd3, 1'b1, 0, 48);
        test_random_phase(250, 16'd1, 16'd0, 1'b0, 31, 31);
        test_backpressure();
        test_extremes();

        wait_results_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d transactions, checked %0d results, %0d mismatches.",
                 items_sent, results_checked, mismatches);
        $display("Pulses started %0d, duplicate requests %0d, full-queue rejects %0d.",
                 pulses_started, dup_requests, full_rejects);
        if (mismatches == 0 && pending_pulse_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
